// ===== rtl/core/bmpm_pkg.sv =====
// Shared types and constants of the 24-bit BMP horizontal mirror.
package bmpm_pkg;

  // File header layout.
  localparam int unsigned HDR_LEN   = 54;
  localparam int unsigned HAW       = $clog2(HDR_LEN);
  localparam int unsigned PIX_BYTES = 3;

  localparam logic [HAW-1:0] MAGIC_AT  = HAW'(0);
  localparam logic [HAW-1:0] OFFSET_AT = HAW'(10);
  localparam logic [HAW-1:0] WIDTH_AT  = HAW'(18);
  localparam logic [HAW-1:0] HDR_END   = HAW'(HDR_LEN - 1);

  localparam logic [15:0] BMP_MAGIC   = 16'h4D42;
  localparam logic [31:0] DATA_OFFSET = 32'd54;

  // Depth of the result buffer in front of the output port.
  localparam int unsigned FIFO_DEPTH = 3;

  // Request kinds.
  localparam logic REQ_FILE  = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  // Result status codes.
  typedef logic [1:0] status_t;
  localparam status_t ST_DATA   = 2'd0;
  localparam status_t ST_MAGIC  = 2'd1;
  localparam status_t ST_OFFSET = 2'd2;
  localparam status_t ST_WIDTH  = 2'd3;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_EMIT   = 4'b0010,
    PH_ROWS   = 4'b0100,
    PH_FAILED = 4'b1000
  } phase_e;

  // Where the byte of a result in flight comes from.
  typedef enum logic [1:0] {
    SRC_LINE = 2'd0,
    SRC_HDR  = 2'd1,
    SRC_ERR  = 2'd2
  } src_e;

  typedef struct packed {
    logic    valid;
    src_e    src;
    status_t status;
    logic    last;
  } rd_stage_t;

  typedef struct packed {
    logic [7:0] out_byte;
    status_t    status;
    logic       last;
  } rsp_t;

endpackage

// ===== rtl/core/bmpm_req_if.sv =====
// Request channel of the BMP mirror: file bytes and drain requests.
interface bmpm_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] in_byte;

  modport source (output valid, output req_type, output in_byte, input ready);
  modport sink   (input valid, input req_type, input in_byte, output ready);
endinterface

// ===== rtl/core/bmpm_rsp_if.sv =====
// Result channel of the BMP mirror: output file bytes with status and last flag.
interface bmpm_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       last;

  modport source (output valid, output out_byte, output status, output last, input ready);
  modport sink   (input valid, input out_byte, input status, input last, output ready);
endinterface

// ===== rtl/core/bmpm_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module bmpm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/bmp24_horizontal_mirror.sv =====
// Top level of the 24-bit BMP horizontal mirror.
// A row byte or an error result passes the read stage register and the result buffer on its way
// to the output; the header replay follows the last header byte, one byte a cycle while the buffer has room.
// Throughput: one request per cycle in the pixel rows while the result buffer has room, set by the
// line RAM's one read and one write port; no request is taken during the 54-byte header replay.
// Reset clears all control state; the header and line RAMs are not cleared, since an
// entry is always written before it is read.
module bmp24_horizontal_mirror #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  bmpm_req_if.sink    req_i,
  bmpm_rsp_if.source  rsp_o
);
  import bmpm_pkg::*;

  localparam int unsigned BANK_BYTES = ((PIX_BYTES * MAX_WIDTH + 3) / 4) * 4;
  localparam int unsigned LINE_DEPTH = 2 * BANK_BYTES;
  localparam int unsigned LAW        = $clog2(LINE_DEPTH);
  localparam int unsigned CW         = $clog2(BANK_BYTES + 1);

  phase_e          phase_q, phase_d;
  logic [HAW-1:0]  hdr_cnt_q, hdr_cnt_d;
  logic [HAW-1:0]  emit_q, emit_d;
  logic [15:0]     magic_q, magic_d;
  logic [31:0]     offs_q, offs_d;
  logic [31:0]     wid_q, wid_d;
  logic [CW-1:0]   active_q, active_d;
  logic [CW-1:0]   row_bytes_q, row_bytes_d;
  logic [CW-1:0]   wpos_q, wpos_d;
  logic [CW-1:0]   rpos_q, rpos_d;
  logic [CW-1:0]   mir_q, mir_d;
  logic [1:0]      comp_q, comp_d;
  logic            bank_q, bank_d;
  logic            pending_q, pending_d;
  rd_stage_t       s1_q, s1_d;

  rsp_t            fifo_q [FIFO_DEPTH];
  logic [1:0]      cnt_q, cnt_d;
  logic [1:0]      wr_q, wr_d;
  logic [1:0]      rd_q, rd_d;

  logic            hdr_we, hdr_re;
  logic [7:0]      hdr_rdata;
  logic            line_we, line_re;
  logic [LAW-1:0]  line_waddr, line_raddr;
  logic [7:0]      line_rdata;

  logic            in_fire, credit_ok, push, pop;
  status_t         hdr_status;
  logic [HAW-1:0]  off_idx, wid_idx;
  logic [CW+1:0]   pix_bytes, pad_bytes;
  logic [CW-1:0]   rd_off, rpos_inc, wpos_inc;
  rsp_t            push_entry;

  // Handshake and credit: a request is taken only if its result has a buffer slot.
  assign in_fire     = req_i.valid && req_i.ready;
  assign credit_ok   = ({1'b0, cnt_q} + 3'(s1_q.valid)) < 3'(FIFO_DEPTH);
  assign req_i.ready = credit_ok && (phase_q != PH_EMIT);

  // Header check, in order of precedence: magic, data offset, width range.
  always_comb begin
    if (magic_q != BMP_MAGIC) begin
      hdr_status = ST_MAGIC;
    end else if (offs_q != DATA_OFFSET) begin
      hdr_status = ST_OFFSET;
    end else if (wid_q[31] || (wid_q == 32'd0) || (wid_q > 32'(MAX_WIDTH))) begin
      hdr_status = ST_WIDTH;
    end else begin
      hdr_status = ST_DATA;
    end
  end

  // Active pixel bytes of a row and the row length padded to four bytes.
  assign pix_bytes = (CW+2)'(wid_q[CW-1:0]) * (CW+2)'(PIX_BYTES);
  assign pad_bytes = (pix_bytes + (CW+2)'(3)) & ~(CW+2)'(3);

  assign off_idx  = hdr_cnt_q - OFFSET_AT;
  assign wid_idx  = hdr_cnt_q - WIDTH_AT;
  assign rpos_inc = rpos_q + CW'(1);
  assign wpos_inc = wpos_q + CW'(1);

  // Line RAM addresses: reads come from the bank not being written.
  assign rd_off     = (rpos_q < active_q) ? mir_q : rpos_q;
  assign line_raddr = bank_q ? LAW'(rd_off) : LAW'(rd_off) + LAW'(BANK_BYTES);
  assign line_waddr = bank_q ? LAW'(wpos_q) + LAW'(BANK_BYTES) : LAW'(wpos_q);

  // Main control: header capture, header replay and row streaming.
  always_comb begin
    phase_d     = phase_q;
    hdr_cnt_d   = hdr_cnt_q;
    emit_d      = emit_q;
    magic_d     = magic_q;
    offs_d      = offs_q;
    wid_d       = wid_q;
    active_d    = active_q;
    row_bytes_d = row_bytes_q;
    wpos_d      = wpos_q;
    rpos_d      = rpos_q;
    mir_d       = mir_q;
    comp_d      = comp_q;
    bank_d      = bank_q;
    pending_d   = pending_q;
    s1_d        = '{valid: 1'b0, src: SRC_LINE, status: ST_DATA, last: 1'b0};
    hdr_we      = 1'b0;
    hdr_re      = 1'b0;
    line_we     = 1'b0;
    line_re     = 1'b0;

    case (phase_q)
      PH_HEADER: begin
        if (in_fire && (req_i.req_type == REQ_FILE)) begin
          hdr_we    = 1'b1;
          hdr_cnt_d = hdr_cnt_q + HAW'(1);
          if (hdr_cnt_q == MAGIC_AT) begin
            magic_d[7:0] = req_i.in_byte;
          end
          if (hdr_cnt_q == MAGIC_AT + HAW'(1)) begin
            magic_d[15:8] = req_i.in_byte;
          end
          if ((hdr_cnt_q >= OFFSET_AT) && (hdr_cnt_q < OFFSET_AT + HAW'(4))) begin
            offs_d[{off_idx[1:0], 3'b000} +: 8] = req_i.in_byte;
          end
          if ((hdr_cnt_q >= WIDTH_AT) && (hdr_cnt_q < WIDTH_AT + HAW'(4))) begin
            wid_d[{wid_idx[1:0], 3'b000} +: 8] = req_i.in_byte;
          end
          if (hdr_cnt_q == HDR_END) begin
            if (hdr_status != ST_DATA) begin
              s1_d    = '{valid: 1'b1, src: SRC_ERR, status: hdr_status, last: 1'b1};
              phase_d = PH_FAILED;
            end else begin
              phase_d     = PH_EMIT;
              emit_d      = '0;
              active_d    = pix_bytes[CW-1:0];
              row_bytes_d = pad_bytes[CW-1:0];
            end
          end
        end
      end
      PH_EMIT: begin
        if (credit_ok) begin
          hdr_re = 1'b1;
          s1_d   = '{valid: 1'b1, src: SRC_HDR, status: ST_DATA, last: (emit_q == HDR_END)};
          emit_d = emit_q + HAW'(1);
          if (emit_q == HDR_END) begin
            phase_d   = PH_ROWS;
            wpos_d    = '0;
            rpos_d    = '0;
            bank_d    = 1'b0;
            pending_d = 1'b0;
          end
        end
      end
      PH_ROWS: begin
        if (in_fire) begin
          // One byte of the pending row leaves, pixels in reversed order.
          if (pending_q) begin
            line_re = 1'b1;
            s1_d    = '{valid: 1'b1, src: SRC_LINE, status: ST_DATA,
                        last: (req_i.req_type == REQ_DRAIN) && (rpos_inc == row_bytes_q)};
            rpos_d  = rpos_inc;
            if (rpos_inc == row_bytes_q) begin
              pending_d = 1'b0;
            end
            if (comp_q == 2'(PIX_BYTES - 1)) begin
              mir_d  = mir_q - CW'(2 * PIX_BYTES - 1);
              comp_d = '0;
            end else begin
              mir_d  = mir_q + CW'(1);
              comp_d = comp_q + 2'd1;
            end
          end
          // A file byte goes into the bank being filled.
          if (req_i.req_type == REQ_FILE) begin
            line_we = 1'b1;
            wpos_d  = wpos_inc;
            if (wpos_inc == row_bytes_q) begin
              bank_d    = ~bank_q;
              wpos_d    = '0;
              rpos_d    = '0;
              pending_d = 1'b1;
              mir_d     = active_q - CW'(PIX_BYTES);
              comp_d    = '0;
            end
          end
        end
      end
      PH_FAILED: begin
        // Every further request is dropped.
      end
      default: begin
        phase_d = PH_HEADER;
      end
    endcase
  end

  // Header store.
  bmpm_ram #(
    .WIDTH (8),
    .DEPTH (HDR_LEN)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .waddr_i (hdr_cnt_q),
    .wdata_i (req_i.in_byte),
    .re_i    (hdr_re),
    .raddr_i (emit_q),
    .rdata_o (hdr_rdata)
  );

  // Two-bank line store; read and write always fall in different banks.
  bmpm_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (line_we),
    .waddr_i (line_waddr),
    .wdata_i (req_i.in_byte),
    .re_i    (line_re),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  // Result buffer: the read stage pushes, the output port pops.
  assign push = s1_q.valid;
  assign pop  = rsp_o.valid && rsp_o.ready;

  always_comb begin
    push_entry.status = s1_q.status;
    push_entry.last   = s1_q.last;
    case (s1_q.src)
      SRC_HDR:  push_entry.out_byte = hdr_rdata;
      SRC_LINE: push_entry.out_byte = line_rdata;
      default:  push_entry.out_byte = 8'h00;
    endcase
  end

  always_comb begin
    cnt_d = cnt_q + 2'(push) - 2'(pop);
    wr_d  = wr_q;
    rd_d  = rd_q;
    if (push) begin
      wr_d = (wr_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : wr_q + 2'd1;
    end
    if (pop) begin
      rd_d = (rd_q == 2'(FIFO_DEPTH - 1)) ? 2'd0 : rd_q + 2'd1;
    end
  end

  assign rsp_o.valid    = (cnt_q != 2'd0);
  assign rsp_o.out_byte = fifo_q[rd_q].out_byte;
  assign rsp_o.status   = fifo_q[rd_q].status;
  assign rsp_o.last     = fifo_q[rd_q].last;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_HEADER;
      hdr_cnt_q   <= '0;
      emit_q      <= '0;
      active_q    <= '0;
      row_bytes_q <= '0;
      wpos_q      <= '0;
      rpos_q      <= '0;
      mir_q       <= '0;
      comp_q      <= '0;
      bank_q      <= 1'b0;
      pending_q   <= 1'b0;
      s1_q        <= '{valid: 1'b0, src: SRC_LINE, status: ST_DATA, last: 1'b0};
      cnt_q       <= '0;
      wr_q        <= '0;
      rd_q        <= '0;
    end else begin
      phase_q     <= phase_d;
      hdr_cnt_q   <= hdr_cnt_d;
      emit_q      <= emit_d;
      active_q    <= active_d;
      row_bytes_q <= row_bytes_d;
      wpos_q      <= wpos_d;
      rpos_q      <= rpos_d;
      mir_q       <= mir_d;
      comp_q      <= comp_d;
      bank_q      <= bank_d;
      pending_q   <= pending_d;
      s1_q        <= s1_d;
      cnt_q       <= cnt_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    magic_q <= magic_d;
    offs_q  <= offs_d;
    wid_q   <= wid_d;
    if (push) begin
      fifo_q[wr_q] <= push_entry;
    end
  end

  // The credit check keeps a slot free for every read in flight.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((cnt_q == 2'(FIFO_DEPTH)) && s1_q.valid))
    else $error("result buffer overflow");

  // A row read never hits the entry being written in the same cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (line_we && line_re) |-> (line_waddr != line_raddr))
    else $error("line store read and write collide");

  // A pending row always has bytes left to send.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q |-> (rpos_q < row_bytes_q))
    else $error("pending row already fully read");

  // An error result is only produced together with entering the failed state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_q.valid && (s1_q.src == SRC_ERR)) |-> (phase_q == PH_FAILED))
    else $error("error result outside the failed state");

  // The header replay index stays inside the header store.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_EMIT) |-> (emit_q <= HDR_END))
    else $error("header replay index out of range");

endmodule
